### rtl/kmce_pkg.sv
// Shared types and constants for the keypad matrix change-event block.
// No dependencies; every other file of the block except kmce_ram imports this package.
package kmce_pkg;

  localparam int MAX_ROWS     = 18;
  localparam int MAX_COLS     = 8;
  localparam int UNKNOWN_CODE = 240;
  localparam int TABLE_DEPTH  = MAX_ROWS * MAX_COLS;

  // Field widths fixed by the item formats
  localparam int REQ_W  = 2;
  localparam int ROW_W  = 5;
  localparam int BITS_W = 8;
  localparam int SLOT_W = 8;
  localparam int CODE_W = 10;
  localparam int KEY_W  = 8;

  // Configuration register widths and reset values
  localparam int COLS_CFG_W = 4;
  localparam int ROWS_CFG_W = 5;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam logic [COLS_CFG_W-1:0] COLS_RST = COLS_CFG_W'(8);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'(18);
  localparam logic [CFG_IDX_W-1:0]  REG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_ROWS = 1'b1;

  localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CMP_W = ROW_W + 1;

  localparam logic [BITS_W-1:0] ROW_IDLE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SINGLE = 2'd0,
    REQ_MULTI  = 2'd1,
    REQ_STUCK  = 2'd2,
    REQ_LOAD   = 2'd3
  } req_t;

  // One key event handed from the row sequencer to the code lookup
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] idx;
    logic             pressed;
    logic             last;
  } evt_req_t;

  // Keymap entry write
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] value;
  } map_wr_t;

endpackage

### rtl/kmce_in_if.sv
// Input channel of the keypad change-event block: valid/ready plus one scan item.
// Depends on kmce_pkg for field widths.
interface kmce_in_if import kmce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ROW_W-1:0]  row_number;
  logic [BITS_W-1:0] older_bits;
  logic [BITS_W-1:0] newer_bits;
  logic [SLOT_W-1:0] map_slot;
  logic [CODE_W-1:0] map_value;

  modport source (output valid, req_type, row_number, older_bits, newer_bits, map_slot,
                  map_value, input ready);
  modport sink   (input valid, req_type, row_number, older_bits, newer_bits, map_slot,
                  map_value, output ready);
endinterface

### rtl/kmce_out_if.sv
// Result channel of the keypad change-event block: valid/ready plus one key event.
// Depends on kmce_pkg for field widths.
interface kmce_out_if import kmce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_index;
  logic [CODE_W-1:0] key_code;
  logic              pressed;
  logic              last_event;

  modport source (output valid, key_index, key_code, pressed, last_event, input ready);
  modport sink   (input valid, key_index, key_code, pressed, last_event, output ready);
endinterface

### rtl/kmce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kmce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kmce_row_seq.sv
// Row sequencer: known-row RAM read-modify-write, change masks and event issue.
// Depends on kmce_pkg, kmce_in_if and kmce_ram.
module kmce_row_seq import kmce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  kmce_in_if.sink               in_ch,
  input  logic [COLS_CFG_W-1:0] cols_cfg,
  input  logic [ROWS_CFG_W-1:0] rows_cfg,
  output evt_req_t              evt,
  input  logic                  evt_ready,
  output map_wr_t               map_wr
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  localparam int PROD_W = ROW_AW + COLS_CFG_W;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [ROW_AW-1:0]     row_r;
  logic [BITS_W-1:0]     older_r, newer_r;
  logic [MAX_COLS-1:0]   mask1_r, mask1_nxt, mask2_r, mask2_nxt;
  logic [MAX_COLS-1:0]   next1_r, next2_r;
  logic [KEY_W-1:0]      base_r;
  logic [MAX_ROWS-1:0]   valid_r, valid_nxt;

  req_t                  in_req;
  logic                  in_fire, row_ok, issue, use_first;
  logic [COLS_CFG_W-1:0] cols_eff;
  logic [MAX_COLS-1:0]   col_mask, mask_sel;
  logic [BITS_W-1:0]     ram_rdata, prev_row, first_row;
  logic                  ram_we;
  logic [PROD_W-1:0]     prod;
  logic [COL_IDX_W-1:0]  col;

  function automatic logic [COL_IDX_W-1:0] low_bit(input logic [MAX_COLS-1:0] m);
    logic [COL_IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (m[i]) r = COL_IDX_W'(i);
    end
    return r;
  endfunction

  assign in_req   = req_t'(in_ch.req_type);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign row_ok   = (in_ch.row_number < rows_cfg)
                 && (ROW_CMP_W'(in_ch.row_number) < ROW_CMP_W'(MAX_ROWS));
  assign cols_eff = (cols_cfg > COLS_CFG_W'(MAX_COLS)) ? COLS_CFG_W'(MAX_COLS) : cols_cfg;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (COLS_CFG_W'(c) < cols_cfg);
    end
  end

  // Keymap loads go straight to the code table
  assign map_wr.we    = in_fire && (in_req == REQ_LOAD)
                     && (SLOT_W'(in_ch.map_slot) < SLOT_W'(TABLE_DEPTH - 1) + SLOT_W'(1)
                         || TABLE_DEPTH > (1 << SLOT_W) - 1);
  assign map_wr.slot  = in_ch.map_slot;
  assign map_wr.value = in_ch.map_value;

  assign ram_we = (state_r == ST_LOAD) && (req_r != REQ_STUCK);

  kmce_ram #(.WIDTH(BITS_W), .DEPTH(MAX_ROWS)) u_known_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_r),
    .wdata (newer_r),
    .re    (in_fire),
    .raddr (in_ch.row_number[ROW_AW-1:0]),
    .rdata (ram_rdata)
  );

  // A row never written still holds its idle pattern
  assign prev_row  = (req_r == REQ_STUCK || !valid_r[row_r]) ? ROW_IDLE : ram_rdata;
  assign first_row = (req_r == REQ_MULTI) ? older_r : newer_r;
  assign prod      = PROD_W'(row_r) * PROD_W'(cols_eff);

  // Event issue: drain the first comparison before the second
  assign use_first = (mask1_r != '0);
  assign mask_sel  = use_first ? mask1_r : mask2_r;
  assign col       = low_bit(mask_sel);
  assign evt.valid = (state_r == ST_SCAN) && ((mask1_r | mask2_r) != '0);
  assign issue     = evt.valid && evt_ready;
  assign evt.idx   = base_r + KEY_W'(col);
  assign evt.pressed = use_first ? !next1_r[col] : !next2_r[col];
  assign evt.last  = ((mask1_nxt | mask2_nxt) == '0);

  always_comb begin
    mask1_nxt = mask1_r;
    mask2_nxt = mask2_r;
    if (use_first) begin
      mask1_nxt = mask1_r & (mask1_r - MAX_COLS'(1));
    end else begin
      mask2_nxt = mask2_r & (mask2_r - MAX_COLS'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_req != REQ_LOAD && row_ok) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (ram_we) valid_nxt[row_r] = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!evt.valid || (issue && evt.last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      mask1_r <= '0;
      mask2_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (state_r == ST_LOAD) begin
        mask1_r <= (prev_row[MAX_COLS-1:0] ^ first_row[MAX_COLS-1:0]) & col_mask;
        mask2_r <= (req_r == REQ_MULTI)
                 ? ((older_r[MAX_COLS-1:0] ^ newer_r[MAX_COLS-1:0]) & col_mask) : '0;
      end else if (issue) begin
        mask1_r <= mask1_nxt;
        mask2_r <= mask2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_req;
      row_r   <= in_ch.row_number[ROW_AW-1:0];
      older_r <= in_ch.older_bits;
      newer_r <= in_ch.newer_bits;
    end
    if (state_r == ST_LOAD) begin
      base_r  <= KEY_W'(prod);
      next1_r <= first_row[MAX_COLS-1:0];
      next2_r <= newer_r[MAX_COLS-1:0];
    end
  end

endmodule

### rtl/kmce_code_lookup.sv
// Code lookup: keymap RAM read per event, code substitution and output register.
// Depends on kmce_pkg, kmce_out_if and kmce_ram.
module kmce_code_lookup import kmce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  evt_req_t evt,
  output logic     evt_ready,
  input  map_wr_t  map_wr,
  kmce_out_if.source out_ch
);

  localparam int SLOT_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic              b_vld_r, b_vld_nxt;
  logic [KEY_W-1:0]  b_idx_r;
  logic              b_pressed_r, b_last_r;
  logic              out_vld_r, out_vld_nxt;
  logic [KEY_W-1:0]  out_idx_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_pressed_r, out_last_r;

  logic              out_free, b_move, issue;
  logic [CODE_W-1:0] code_rdata;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign b_move    = b_vld_r && out_free;
  // Hold the read data while the lookup stage is stalled
  assign evt_ready = !b_vld_r || out_free;
  assign issue     = evt.valid && evt_ready;

  kmce_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_code_ram (
    .clk   (clk),
    .we    (map_wr.we),
    .waddr (SLOT_AW'(map_wr.slot)),
    .wdata (map_wr.value),
    .re    (issue),
    .raddr (SLOT_AW'(evt.idx)),
    .rdata (code_rdata)
  );

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (issue) begin
      b_vld_nxt = 1'b1;
    end else if (b_move) begin
      b_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (b_move) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_idx_r     <= evt.idx;
      b_pressed_r <= evt.pressed;
      b_last_r    <= evt.last;
    end
    if (b_move) begin
      out_idx_r     <= b_idx_r;
      out_code_r    <= (code_rdata == '0) ? CODE_W'(UNKNOWN_CODE) : code_rdata;
      out_pressed_r <= b_pressed_r;
      out_last_r    <= b_last_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.key_index  = out_idx_r;
  assign out_ch.key_code   = out_code_r;
  assign out_ch.pressed    = out_pressed_r;
  assign out_ch.last_event = out_last_r;

endmodule

### rtl/keypad_matrix_change_events_core.sv
// Top level of the keypad matrix change-event block: configuration registers and
// the row sequencer feeding the code lookup. Depends on kmce_pkg, the channel
// interfaces, kmce_row_seq and kmce_code_lookup.
//
// Each input item is either one drive row's scan bits or a keymap load. A keymap
// load and a row at or beyond the row count leave the input ready and produce
// nothing. A row item passes through a read of the stored row from its RAM, then
// compare and write-back, then a scan that issues its key events one at a time,
// waiting while the code lookup holds off, since the keymap RAM is looked up once
// per cycle; a row with no change still enters the scan state. The next item is
// taken once the last event of the current one has been issued, while earlier
// events still drain through the output register. Keymap entries hold no value
// until loaded; an event on a key whose entry was never loaded carries an undefined
// code. Events with a zero entry report the unknown code. Configuration writes
// apply to later items if the user makes them between items; nothing enforces it.
module keypad_matrix_change_events_core import kmce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  kmce_in_if.sink              in_chan,
  kmce_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [COLS_CFG_W-1:0] cols_r;
  logic [ROWS_CFG_W-1:0] rows_r;
  evt_req_t              evt;
  logic                  evt_ready;
  map_wr_t               map_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: cols_r <= cfg_wdata[COLS_CFG_W-1:0];
        REG_ROWS: rows_r <= cfg_wdata[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  kmce_row_seq u_row_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .cols_cfg  (cols_r),
    .rows_cfg  (rows_r),
    .evt       (evt),
    .evt_ready (evt_ready),
    .map_wr    (map_wr)
  );

  kmce_code_lookup u_code_lookup (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt       (evt),
    .evt_ready (evt_ready),
    .map_wr    (map_wr),
    .out_ch    (out_chan)
  );

endmodule

### rtl/kmce_checker.sv
// Port-level checks for the keypad change-event block, bound to its top level.
// Depends on kmce_pkg and keypad_matrix_change_events_core.
module kmce_checker import kmce_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [REQ_W-1:0]  in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KEY_W-1:0]  out_key_index,
  input logic [CODE_W-1:0] out_key_code
);

  // A waiting event holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_index))
    else $error("event dropped or changed while stalled");

  // Key indexes stay inside the keymap
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_index < KEY_W'(TABLE_DEPTH))
    else $error("key index beyond keymap");

  // A zero entry is always replaced by the unknown code
  a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code != '0)
    else $error("zero key code on output");

  // A keymap load never holds off the next item
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_LOAD |=> in_ready)
    else $error("keymap load blocked the input");

endmodule

bind keypad_matrix_change_events_core kmce_checker u_kmce_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_req_type   (in_chan.req_type),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_key_index (out_chan.key_index),
  .out_key_code  (out_chan.key_code)
);
